### hdl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

  // Default pattern capacity in bytes.
  localparam int DEFAULT_MAX_PATTERN = 16;

  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] STAR_CODE  = 8'h2A;
  localparam logic [CHAR_W-1:0] QMARK_CODE = 8'h3F;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_START  = 2'd2,
    REQ_SOURCE = 2'd3
  } req_type_t;

endpackage

### hdl/wpm_prefix_or.sv
// Log-depth generate/propagate prefix network for the match row.
module wpm_prefix_or #(
  parameter int WIDTH = wpm_pkg::DEFAULT_MAX_PATTERN + 1
) (
  input  logic [WIDTH-1:0] gen_i,
  input  logic [WIDTH-1:0] prop_i,
  output logic [WIDTH-1:0] row_o
);

  localparam int LVLS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] g_lvl [LVLS+1];
  logic [WIDTH-1:0] p_lvl [LVLS+1];

  // row[j] = g[j] | p[j] & row[j-1], resolved in log2(WIDTH) levels
  always_comb begin
    g_lvl[0] = gen_i;
    p_lvl[0] = prop_i;
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < WIDTH; j++) begin
        if (j >= (1 << l)) begin
          g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
          p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
        end else begin
          g_lvl[l+1][j] = g_lvl[l][j];
          p_lvl[l+1][j] = p_lvl[l][j];
        end
      end
    end
    row_o = g_lvl[LVLS];
  end

endmodule

### hdl/wpm_core.sv
// Pattern store, match row state and the row update.
module wpm_core #(
  parameter int MAX_PATTERN = wpm_pkg::DEFAULT_MAX_PATTERN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire_i,
  input  logic [1:0]                 req_i,
  input  logic [wpm_pkg::CHAR_W-1:0] char_i,
  output logic                       matched_o,
  output logic                       overflow_o
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int ROW_W = MAX_PATTERN + 1;

  logic [wpm_pkg::CHAR_W-1:0] store_r [MAX_PATTERN];
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic                       ovf_r, ovf_nxt;

  wpm_pkg::req_type_t req;
  logic               is_append, is_source, room, wr_en;
  logic [MAX_PATTERN-1:0] star_vec, hit_vec;
  logic [ROW_W-1:0]       gen, prop;

  assign req = wpm_pkg::req_type_t'(req_i);

  always_comb begin
    is_append = 1'b0;
    is_source = 1'b0;
    count_nxt = count_r;
    room      = (count_r < CNT_W'(MAX_PATTERN));
    case (req)
      wpm_pkg::REQ_CLEAR:  count_nxt = '0;
      wpm_pkg::REQ_APPEND: begin
        is_append = 1'b1;
        if (room) count_nxt = count_r + CNT_W'(1);
      end
      wpm_pkg::REQ_START:  ;
      wpm_pkg::REQ_SOURCE: is_source = 1'b1;
      default:             ;
    endcase
    ovf_nxt = ovf_r | (is_append & ~room);
    wr_en   = fire_i & is_append & room;

    // Star flags see a byte being appended this cycle.
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (is_append && room && (count_r == CNT_W'(k)))
        star_vec[k] = (char_i == wpm_pkg::STAR_CODE);
      else
        star_vec[k] = (store_r[k] == wpm_pkg::STAR_CODE);
      hit_vec[k] = (store_r[k] == char_i) || (store_r[k] == wpm_pkg::QMARK_CODE);
    end

    if (is_source) begin
      gen[0]  = 1'b0;
      prop[0] = 1'b0;
      for (int j = 1; j < ROW_W; j++) begin
        if (CNT_W'(j) <= count_r) begin
          gen[j]  = star_vec[j-1] ? row_r[j] : (hit_vec[j-1] & row_r[j-1]);
          prop[j] = star_vec[j-1];
        end else begin
          gen[j]  = 1'b0;
          prop[j] = 1'b0;
        end
      end
    end else begin
      // Restart: empty-source row with the leading-star run.
      gen[0]  = 1'b1;
      prop[0] = 1'b0;
      for (int j = 1; j < ROW_W; j++) begin
        gen[j]  = 1'b0;
        prop[j] = (CNT_W'(j) <= count_nxt) & star_vec[j-1];
      end
    end
  end

  wpm_prefix_or #(.WIDTH(ROW_W)) u_prefix (
    .gen_i  (gen),
    .prop_i (prop),
    .row_o  (row_nxt)
  );

  assign matched_o  = row_nxt[count_nxt];
  assign overflow_o = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      row_r   <= ROW_W'(1);
      ovf_r   <= 1'b0;
    end else if (fire_i) begin
      count_r <= count_nxt;
      row_r   <= row_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[count_r[IDX_W-1:0]] <= char_i;
    end
  end

endmodule

### hdl/wildcard_pattern_matcher_unit.sv
// Top level of the streaming glob matcher: input register, row update, result register.
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid, in_stall, in_req_type, in_char_code | request transfer in
//   out     | out_valid, out_stall, out_matched,          | one result per request
//           | out_pattern_overflow                        |
//
// Every request gives exactly one result, via the input and result registers.
// One request per cycle is sustained while the output does not stall: the row
// update between the input register and the result register is a single pass.
// Reset (rst_n low, synchronous) empties both registers, clears the pattern
// length, the overflow flag and the match row to the empty-source row.
// A stall on the output holds the result register and backs up into in_stall
// once the input register is also full.
module wildcard_pattern_matcher_unit #(
  parameter int MAX_PATTERN = wpm_pkg::DEFAULT_MAX_PATTERN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [wpm_pkg::CHAR_W-1:0] in_char_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_matched,
  output logic                       out_pattern_overflow
);

  // Input register
  logic                       in_vld_r;
  logic [1:0]                 in_req_r;
  logic [wpm_pkg::CHAR_W-1:0] in_char_r;

  // Result register
  logic out_vld_r;
  logic out_matched_r;
  logic out_ovf_r;

  logic advance;   // result register can take a new value this cycle
  logic fire;      // request in the input register is processed
  logic matched;
  logic overflow;

  assign advance  = ~out_vld_r | ~out_stall;
  assign fire     = in_vld_r & advance;
  assign in_stall = in_vld_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r  <= in_req_type;
      in_char_r <= in_char_code;
    end
  end

  // State update and match evaluation for the held request.
  wpm_core #(.MAX_PATTERN(MAX_PATTERN)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire_i     (fire),
    .req_i      (in_req_r),
    .char_i     (in_char_r),
    .matched_o  (matched),
    .overflow_o (overflow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_matched_r <= matched;
      out_ovf_r     <= overflow;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

endmodule

### tb/sv/wpm_match_monitor.sv
// Channel monitor, glob match predictor and result comparison for the wildcard pattern matcher.
module wpm_match_monitor
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_matched,
  input  logic              out_pattern_overflow,
  output int unsigned       mismatches,
  output int unsigned       awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic [CHAR_W-1:0]    pat_mem [MAX_PATTERN];
  int unsigned          pat_len;
  logic [MAX_PATTERN:0] prefix_hits;
  logic                 sticky_ovf;
  verdict_t             verdicts_q[$];
  verdict_t             head;
  int unsigned          fails = 0;
  int unsigned          backlog = 0;

  assign mismatches = fails;
  assign awaiting   = backlog;

  // Row for an empty source: only leading stars can match nothing.
  function automatic logic [MAX_PATTERN:0] empty_source_row();
    logic [MAX_PATTERN:0] row;
    row    = '0;
    row[0] = 1'b1;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      if (j <= pat_len && row[j-1] && pat_mem[j-1] == STAR_CODE) begin
        row[j] = 1'b1;
      end else begin
        break;
      end
    end
    return row;
  endfunction

  function automatic logic [MAX_PATTERN:0] advance_row(logic [CHAR_W-1:0] c);
    logic [MAX_PATTERN:0] nxt;
    nxt = '0;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      if (j <= pat_len) begin
        if (pat_mem[j-1] == STAR_CODE) begin
          nxt[j] = nxt[j-1] | prefix_hits[j];
        end else if (pat_mem[j-1] == QMARK_CODE || pat_mem[j-1] == c) begin
          nxt[j] = prefix_hits[j-1];
        end
      end
    end
    return nxt;
  endfunction

  task automatic report(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_len     = 0;
      sticky_ovf  = 1'b0;
      prefix_hits = '0;
      prefix_hits[0] = 1'b1;
      verdicts_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_q.size() == 0) begin
          report("result transfer with nothing outstanding");
        end else begin
          head = verdicts_q.pop_front();
          if (out_matched !== head.matched)
            report($sformatf("matched: expected %0b got %0b", head.matched, out_matched));
          if (out_pattern_overflow !== head.overflow)
            report($sformatf("pattern_overflow: expected %0b got %0b",
                             head.overflow, out_pattern_overflow));
        end
      end
      if (in_valid && !in_stall) begin
        case (req_type_t'(in_req_type))
          REQ_CLEAR: begin
            pat_len     = 0;
            prefix_hits = empty_source_row();
          end
          REQ_APPEND: begin
            if (pat_len < MAX_PATTERN) begin
              pat_mem[pat_len] = in_char_code;
              pat_len++;
            end else begin
              sticky_ovf = 1'b1;
            end
            prefix_hits = empty_source_row();
          end
          REQ_START: begin
            prefix_hits = empty_source_row();
          end
          REQ_SOURCE: begin
            prefix_hits = advance_row(in_char_code);
          end
        endcase
        verdicts_q.insert(verdicts_q.size(),
                          verdict_t'{matched: prefix_hits[pat_len], overflow: sticky_ovf});
      end
    end
    backlog <= verdicts_q.size();
  end

endmodule

### tb/sv/tb.sv
// Top-level bench for the wildcard pattern matcher: clock, reset, stimulus and verdict.
module tb;
  import wpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CHAR_W-1:0] LETTER_A = 8'h61;
  localparam logic [CHAR_W-1:0] LETTER_Z = 8'h7A;
  localparam int HOLD_CYCLES  = 90;   // long receiver hold-off
  localparam int PHASE_ITEMS  = 135;  // random transfers per idling phase

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = REQ_CLEAR;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_matched;
  logic              out_pattern_overflow;

  int unsigned mismatches;
  int unsigned awaiting;

  // Idling knobs, in percent per cycle.
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned items_sent   = 0;

  // Long hold-off handshake: stimulus toggles hold_ask, receiver acknowledges.
  logic hold_ask  = 1'b0;
  logic hold_seen = 1'b0;

  always #5 clk = ~clk;

  wildcard_pattern_matcher_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_char_code         (in_char_code),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow)
  );

  wpm_match_monitor u_monitor (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_char_code         (in_char_code),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow),
    .mismatches           (mismatches),
    .awaiting             (awaiting)
  );

  // Receiver: random stall per cycle, or a long hold-off when asked. The
  // hold-off keeps stalling while the sender keeps offering, so both the
  // result and input registers fill and in_stall backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // One request transfer. Optional idle gap first; valid stays up across
  // back-to-back transfers and the payload holds while stalled.
  task automatic push_req(req_type_t kind, logic [CHAR_W-1:0] code);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_char_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Sender pauses until every outstanding result of the two-stage pipe has
  // been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] letter();
    return LETTER_A + CHAR_W'($urandom_range(2));
  endfunction

  // Source bytes: mostly a small alphabet so matches happen, some raw bytes.
  function automatic logic [CHAR_W-1:0] source_char();
    return ($urandom_range(99) < 90) ? letter() : CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return STAR_CODE;
    if (r < 35) return QMARK_CODE;
    if (r < 85) return letter();
    return CHAR_W'($urandom_range(255));
  endfunction

  // Garbage: arbitrary request kinds and bytes, including appends on top of
  // an old pattern.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      push_req(req_type_t'($urandom_range(3)), CHAR_W'($urandom_range(255)));
  endtask

  // Well-formed job: clear, load a pattern, then a few sources. Most sources
  // are built to fit the pattern (stars expand to short runs), some get one
  // byte corrupted, the rest are random strings.
  task automatic glob_job();
    logic [CHAR_W-1:0] pat[$];
    logic [CHAR_W-1:0] src[$];
    logic [CHAR_W-1:0] ch;
    int unsigned       r;
    int unsigned       plen;
    push_req(REQ_CLEAR, CHAR_W'($urandom_range(255)));
    r    = $urandom_range(99);
    plen = (r < 70) ? $urandom_range(1, 6) :
           (r < 95) ? $urandom_range(7, 16) : $urandom_range(17, 18);
    repeat (plen) begin
      ch = pattern_char();
      pat.insert(pat.size(), ch);
      push_req(REQ_APPEND, ch);
    end
    repeat ($urandom_range(1, 3)) begin
      push_req(REQ_START, CHAR_W'($urandom_range(255)));
      src.delete();
      if ($urandom_range(99) < 60) begin
        // Only the first 16 bytes made it into the pattern.
        for (int i = 0; i < pat.size() && i < DEFAULT_MAX_PATTERN; i++) begin
          if (pat[i] == STAR_CODE) begin
            repeat ($urandom_range(0, 3)) src.insert(src.size(), source_char());
          end else if (pat[i] == QMARK_CODE) begin
            src.insert(src.size(), source_char());
          end else begin
            src.insert(src.size(), pat[i]);
          end
        end
        if ($urandom_range(99) < 25 && src.size() > 0)
          src[$urandom_range(src.size() - 1)] = letter();
      end else begin
        repeat ($urandom_range(0, 8)) src.insert(src.size(), source_char());
      end
      foreach (src[k]) push_req(REQ_SOURCE, src[k]);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pattern, leading star ripple, extreme bytes, '?',
    // fill to capacity, dropped append with sticky overflow, clear keeps flag.
    push_req(REQ_SOURCE, 8'hFF);        // empty pattern after a byte: no match
    push_req(REQ_START, 8'h00);         // empty pattern, empty source: match
    push_req(REQ_CLEAR, 8'hFF);
    push_req(REQ_APPEND, STAR_CODE);
    push_req(REQ_APPEND, STAR_CODE);    // leading stars match empty source
    push_req(REQ_SOURCE, 8'h00);
    push_req(REQ_APPEND, QMARK_CODE);
    push_req(REQ_SOURCE, 8'hFF);
    repeat (13) push_req(REQ_APPEND, LETTER_A);  // pattern now full
    push_req(REQ_APPEND, LETTER_Z);     // dropped, overflow raised
    push_req(REQ_SOURCE, LETTER_A);
    push_req(REQ_CLEAR, 8'h00);         // overflow stays set
    wait_drained();

    // Idling phases: none, sender gaps, receiver stalls, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 88; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 88; end
        default: begin send_gap_pct = 24; stall_pct = 24; end
      endcase
      // Back-pressure test rides on the first phase, sender at full rate.
      if (phase == 0) hold_ask <= ~hold_ask;
      while (items_sent < (phase + 1) * PHASE_ITEMS + 24) begin
        if ($urandom_range(99) < 10) noise_burst();
        else glob_job();
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
